// ===== rtl/set_assoc_cache_byte_access_core_macros.svh =====
// assertion macros for the byte access cache checker
`ifndef SET_ASSOC_CACHE_BYTE_ACCESS_CORE_MACROS_SVH
`define SET_ASSOC_CACHE_BYTE_ACCESS_CORE_MACROS_SVH

// checked only while out of reset
`define SACBA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// checked at every edge, reset included
`define SACBA_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/sacba_pkg.sv =====
// shared constants, payload types and command type of the byte access cache
package sacba_pkg;
	localparam int SETS       = 16;
	localparam int WAYS       = 4;
	localparam int LINE_BYTES = 256;
	localparam int SET_W      = $clog2(SETS);
	localparam int WAY_W      = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int OFF_W      = $clog2(LINE_BYTES);
	localparam int ADDR_W     = SET_W + WAY_W + OFF_W;
	localparam int MEM_DEPTH  = SETS * (1 << WAY_W) * LINE_BYTES;
	localparam int TAG_W      = 20;
	localparam int CNT_W      = 32;

	localparam logic [1:0] FUNC_READ  = 2'd0;
	localparam logic [1:0] FUNC_WRITE = 2'd1;
	localparam logic [1:0] FUNC_INVAL = 2'd2;

	typedef struct packed {
		logic [1:0]       func;
		logic [3:0]       set_index;
		logic [7:0]       byte_offset;
		logic [TAG_W-1:0] line_tag;
		logic [7:0]       write_byte;
		logic             starts_access;
	} in_t;

	typedef struct packed {
		logic             hit;
		logic [7:0]       read_byte;
		logic [CNT_W-1:0] hit_total;
		logic [CNT_W-1:0] miss_total;
	} out_t;

	typedef struct packed {
		logic              mem_wr;
		logic              mem_rd;
		logic              hit;
		logic [ADDR_W-1:0] addr;
		logic [7:0]        wbyte;
		logic [CNT_W-1:0]  hit_total;
		logic [CNT_W-1:0]  miss_total;
	} cmd_t;
endpackage

// ===== rtl/sacba_front.sv =====
// front end: tag lookup, allocation, valid bits and access counters
module sacba_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            accept,
	input  sacba_pkg::in_t  req,
	output sacba_pkg::cmd_t cmd
);
	import sacba_pkg::*;

	logic [SETS-1:0][WAYS-1:0]  valid_q;
	logic [WAYS-1:0][TAG_W-1:0] tags_q [SETS];
	logic [CNT_W-1:0]           hit_q;
	logic [CNT_W-1:0]           miss_q;

	logic [SET_W-1:0] set;
	logic [OFF_W-1:0] off;
	logic [WAYS-1:0]  match;
	logic             found;
	logic [WAY_W-1:0] hit_way;
	logic [WAY_W-1:0] victim;
	logic [WAY_W-1:0] way;
	logic             is_rw;
	logic             cnt_hit;
	logic             cnt_miss;
	logic [CNT_W-1:0] hit_nx;
	logic [CNT_W-1:0] miss_nx;
	logic             alloc;

	always_comb begin
		set     = req.set_index[SET_W-1:0];
		off     = req.byte_offset[OFF_W-1:0];
		hit_way = '0;
		victim  = '0;
		for (int w = 0; w < WAYS; w++) begin
			match[w] = valid_q[set][w] && (tags_q[set][w] == req.line_tag);
		end
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (match[w]) begin
				hit_way = WAY_W'(w);
			end
			if (!valid_q[set][w]) begin
				victim = WAY_W'(w);
			end
		end
		found    = |match;
		way      = found ? hit_way : victim;
		is_rw    = (req.func == FUNC_READ) || (req.func == FUNC_WRITE);
		cnt_hit  = is_rw && req.starts_access && found;
		cnt_miss = is_rw && req.starts_access && !found;
		hit_nx   = hit_q + CNT_W'(cnt_hit);
		miss_nx  = miss_q + CNT_W'(cnt_miss);
		alloc    = (req.func == FUNC_WRITE) && !found;

		cmd.mem_wr     = (req.func == FUNC_WRITE);
		cmd.mem_rd     = (req.func == FUNC_READ) && found;
		cmd.hit        = is_rw && found;
		cmd.addr       = {set, way, off};
		cmd.wbyte      = req.write_byte;
		cmd.hit_total  = hit_nx;
		cmd.miss_total = miss_nx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			hit_q   <= '0;
			miss_q  <= '0;
		end else if (accept) begin
			hit_q  <= hit_nx;
			miss_q <= miss_nx;
			if (req.func == FUNC_INVAL) begin
				valid_q <= '0;
			end else if (alloc) begin
				valid_q[set][victim] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && alloc) begin
			tags_q[set][victim] <= req.line_tag;
		end
	end
endmodule

// ===== rtl/sacba_cmdq.sv =====
// two-entry command queue between front and back end
module sacba_cmdq (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  sacba_pkg::cmd_t din,
	input  logic            pop,
	output sacba_pkg::cmd_t dout,
	output logic            full,
	output logic            empty
);
	import sacba_pkg::*;

	cmd_t       slot_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign dout  = slot_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (pop) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wp_q] <= din;
		end
	end
endmodule

// ===== rtl/sacba_back.sv =====
// back end: data store with clearing sweep, read stage and result queue
module sacba_back (
	input  logic             clk,
	input  logic             arst_n,
	input  sacba_pkg::cmd_t  cmd,
	input  logic             cmd_empty,
	output logic             cmd_pop,
	output logic             busy,
	input  logic             pop,
	output logic             empty,
	output sacba_pkg::out_t  rsp
);
	import sacba_pkg::*;

	logic [7:0]        mem [MEM_DEPTH];
	logic [7:0]        rd_q;
	logic              clr_q;
	logic [ADDR_W-1:0] clr_addr_q;
	logic              valid_s1;
	cmd_t              cmd_s1;
	out_t              res_q [2];
	logic              rwp_q;
	logic              rrp_q;
	logic [1:0]        rcnt_q;

	logic              deq;
	logic [2:0]        occ;
	logic              issue;
	logic              mem_we;
	logic [ADDR_W-1:0] mem_wa;
	logic [7:0]        mem_wd;
	out_t              res_new;

	always_comb begin
		deq     = pop && (rcnt_q != 2'd0);
		occ     = {1'b0, rcnt_q} + {2'b00, valid_s1} - {2'b00, deq};
		issue   = !cmd_empty && !clr_q && (occ < 3'd2);
		mem_we  = clr_q || (issue && cmd.mem_wr);
		mem_wa  = clr_q ? clr_addr_q : cmd.addr;
		mem_wd  = clr_q ? 8'd0 : cmd.wbyte;
		res_new.hit        = cmd_s1.hit;
		res_new.read_byte  = cmd_s1.mem_rd ? rd_q : 8'd0;
		res_new.hit_total  = cmd_s1.hit_total;
		res_new.miss_total = cmd_s1.miss_total;
	end

	assign cmd_pop = issue;
	assign busy    = clr_q;
	assign empty   = (rcnt_q == 2'd0);
	assign rsp     = res_q[rrp_q];

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (issue && cmd.mem_rd) begin
			rd_q <= mem[cmd.addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_q) begin
			clr_addr_q <= clr_addr_q + ADDR_W'(1);
			if (clr_addr_q == ADDR_W'(MEM_DEPTH - 1)) begin
				clr_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			rwp_q    <= 1'b0;
			rrp_q    <= 1'b0;
			rcnt_q   <= 2'd0;
		end else begin
			valid_s1 <= issue;
			if (valid_s1) begin
				rwp_q <= ~rwp_q;
			end
			if (deq) begin
				rrp_q <= ~rrp_q;
			end
			rcnt_q <= rcnt_q + 2'(valid_s1) - 2'(deq);
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			cmd_s1 <= cmd;
		end
		if (valid_s1) begin
			res_q[rwp_q] <= res_new;
		end
	end
endmodule

// ===== rtl/set_assoc_cache_byte_access_core.sv =====
// top level of the four-way set-associative byte access cache
// path: an accepted beat passes the command queue, the read stage and the result queue before its result shows
// throughput: up to one beat per cycle while full is low, set by the single data store port
// reset: queues empty, valid bits and counters cleared at once
// after reset full stays high while the data store is swept to zero
module set_assoc_cache_byte_access_core (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	output logic            full,
	input  sacba_pkg::in_t  req,
	output logic            empty,
	input  logic            pop,
	output sacba_pkg::out_t rsp
);
	import sacba_pkg::*;

	cmd_t fe_cmd;
	cmd_t q_cmd;
	logic q_full;
	logic q_empty;
	logic q_pop;
	logic be_busy;
	logic accept;

	assign full   = q_full || be_busy;
	assign accept = push && !full;

	sacba_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.req    (req),
		.cmd    (fe_cmd)
	);

	sacba_cmdq u_cmdq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (accept),
		.din    (fe_cmd),
		.pop    (q_pop),
		.dout   (q_cmd),
		.full   (q_full),
		.empty  (q_empty)
	);

	sacba_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (q_cmd),
		.cmd_empty (q_empty),
		.cmd_pop   (q_pop),
		.busy      (be_busy),
		.pop       (pop),
		.empty     (empty),
		.rsp       (rsp)
	);
endmodule

// ===== rtl/sacba_checker.sv =====
// port checker for the byte access cache and its bind
`include "set_assoc_cache_byte_access_core_macros.svh"

module sacba_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            push,
	input logic            full,
	input sacba_pkg::in_t  req,
	input logic            empty,
	input logic            pop,
	input sacba_pkg::out_t rsp
);
	import sacba_pkg::*;

	logic [CNT_W-1:0] total;
	logic [CNT_W-1:0] total_q;
	logic [CNT_W-1:0] delta;

	assign total = rsp.hit_total + rsp.miss_total;
	assign delta = total - total_q;

	always_ff @(posedge clk) begin
		total_q <= total;
	end

	`SACBA_ASSERT_ALWAYS(a_empty_in_reset, !arst_n |-> empty, "result queue not empty in reset")
	`SACBA_ASSERT(a_full_after_reset, (!$past(arst_n) && arst_n) |-> full, "input open during clear")
	`SACBA_ASSERT(a_byte_needs_hit, (!empty && rsp.read_byte != 8'd0) |-> rsp.hit, "byte without hit")
	`SACBA_ASSERT(a_count_step, (pop && !empty) ##1 !empty |-> delta <= 32'd1, "counters jumped")
	`SACBA_ASSERT(a_rsp_hold, (!empty && !pop) |=> (!empty && $stable(rsp)), "stalled beat changed")
endmodule

bind set_assoc_cache_byte_access_core sacba_checker u_chk (.*);
